[sv/ncc_pkg.sv]
// Shared types, constants and helpers for the nearest color centroid labeler.
package ncc_pkg;

  localparam int MAX_CENTROIDS = 6;
  localparam int CHAN_W        = 8;
  localparam int SQ_W          = 2 * CHAN_W;
  localparam int DIST_W        = 18;
  localparam int IDX_W         = 3;
  localparam int NUM_W         = 3;
  localparam int CENTROID_W    = 3 * CHAN_W;
  localparam int CFG_IDX_W     = $clog2(MAX_CENTROIDS + 1);
  localparam int CFG_DATA_W    = CENTROID_W;

  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 255 * 255);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTROIDS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_BASE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_ch0;
    logic [CHAN_W-1:0] pixel_ch1;
    logic [CHAN_W-1:0] pixel_ch2;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cluster_index;
    logic [DIST_W-1:0] squared_distance;
  } result_t;

  typedef struct packed {
    pixel_t            pixel;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;
  } cell_word_t;

  function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

[sv/ncc_cell.sv]
// One centroid cell: squares the channel differences, then sums and keeps the nearer centroid.
module ncc_cell (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    up_valid,
  output logic                                    up_ready,
  input  ncc_pkg::cell_word_t                     up_word,
  output logic                                    dn_valid,
  input  logic                                    dn_ready,
  output ncc_pkg::cell_word_t                     dn_word,
  input  logic [ncc_pkg::CENTROID_W-1:0]          centroid,
  input  logic [ncc_pkg::IDX_W-1:0]               cell_idx,
  input  logic                                    active
);

  logic                          a_valid_r;
  ncc_pkg::cell_word_t           a_word_r;
  logic [ncc_pkg::SQ_W-1:0]      a_sq0_r;
  logic [ncc_pkg::SQ_W-1:0]      a_sq1_r;
  logic [ncc_pkg::SQ_W-1:0]      a_sq2_r;
  logic                          b_valid_r;
  ncc_pkg::cell_word_t           b_word_r;
  ncc_pkg::cell_word_t           b_word_nxt;
  logic                          a_ready;
  logic                          b_ready;
  logic [ncc_pkg::DIST_W-1:0]    sum_dist;
  logic                          take;

  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_word_r <= up_word;
      a_sq0_r  <= ncc_pkg::chan_sq(up_word.pixel.pixel_ch0, centroid[7:0]);
      a_sq1_r  <= ncc_pkg::chan_sq(up_word.pixel.pixel_ch1, centroid[15:8]);
      a_sq2_r  <= ncc_pkg::chan_sq(up_word.pixel.pixel_ch2, centroid[23:16]);
    end
  end

  always_comb begin
    sum_dist = ncc_pkg::DIST_W'(a_sq0_r) + ncc_pkg::DIST_W'(a_sq1_r)
             + ncc_pkg::DIST_W'(a_sq2_r);
    take = active && (sum_dist < a_word_r.best_dist);
    b_word_nxt = a_word_r;
    if (take) begin
      b_word_nxt.best_idx  = cell_idx;
      b_word_nxt.best_dist = sum_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_word_r <= b_word_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_word  = b_word_r;

endmodule

[sv/nearest_color_centroid_label.sv]
// Top level of the nearest color centroid labeler: configuration registers and the cell chain.
// Each pixel word travels down a chain of one cell per centroid; every cell first registers
// the squared channel differences and then the sum compared against the best so far, and one
// pixel is accepted every cycle while the result side keeps taking words.
// The chain reports the lowest-numbered centroid among those at the smallest squared
// distance; a centroid count of zero acts as one and a count above the maximum acts as the
// maximum. Centroid and count writes are meant for times when no pixel is in flight.
module nearest_color_centroid_label (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ncc_pkg::pixel_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ncc_pkg::result_t                    out_data,
  input  logic                                cfg_we,
  input  logic [ncc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ncc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [ncc_pkg::NUM_W-1:0]      num_centroids_r;
  logic [ncc_pkg::CENTROID_W-1:0] centroid_r [ncc_pkg::MAX_CENTROIDS];
  logic [ncc_pkg::NUM_W-1:0]      count_eff;
  logic [ncc_pkg::MAX_CENTROIDS-1:0] active;

  logic                   link_valid [ncc_pkg::MAX_CENTROIDS+1];
  logic                   link_ready [ncc_pkg::MAX_CENTROIDS+1];
  ncc_pkg::cell_word_t    link_word  [ncc_pkg::MAX_CENTROIDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_centroids_r <= ncc_pkg::NUM_W'(6);
      for (int k = 0; k < ncc_pkg::MAX_CENTROIDS; k++) begin
        centroid_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == ncc_pkg::REG_NUM_CENTROIDS) begin
        num_centroids_r <= cfg_wdata[ncc_pkg::NUM_W-1:0];
      end
      for (int k = 0; k < ncc_pkg::MAX_CENTROIDS; k++) begin
        if (cfg_index == ncc_pkg::REG_CENTROID_BASE + ncc_pkg::CFG_IDX_W'(k)) begin
          centroid_r[k] <= cfg_wdata;
        end
      end
    end
  end

  always_comb begin
    count_eff = num_centroids_r;
    if (count_eff == '0) begin
      count_eff = ncc_pkg::NUM_W'(1);
    end
    if (count_eff > ncc_pkg::NUM_W'(ncc_pkg::MAX_CENTROIDS)) begin
      count_eff = ncc_pkg::NUM_W'(ncc_pkg::MAX_CENTROIDS);
    end
  end

  // The first cell always wins against the all-ones starting distance.
  assign link_valid[0]                = in_valid;
  assign in_ready                     = link_ready[0];
  assign link_word[0].pixel           = in_data;
  assign link_word[0].best_idx        = '0;
  assign link_word[0].best_dist       = '1;

  for (genvar k = 0; k < ncc_pkg::MAX_CENTROIDS; k++) begin : g_cell
    assign active[k] = count_eff > ncc_pkg::NUM_W'(k);

    ncc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_word  (link_word[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_word  (link_word[k+1]),
      .centroid (centroid_r[k]),
      .cell_idx (ncc_pkg::IDX_W'(k)),
      .active   (active[k])
    );
  end

  assign out_valid                 = link_valid[ncc_pkg::MAX_CENTROIDS];
  assign link_ready[ncc_pkg::MAX_CENTROIDS] = out_ready;
  assign out_data.cluster_index    = link_word[ncc_pkg::MAX_CENTROIDS].best_idx;
  assign out_data.squared_distance = link_word[ncc_pkg::MAX_CENTROIDS].best_dist;

`ifndef SYNTHESIS
  a_idx_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cluster_index < count_eff))
    else $error("Cluster index outside the active centroid count.");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.squared_distance <= ncc_pkg::MAX_DIST))
    else $error("Squared distance above the largest possible value.");

  a_cell0_taken: assert property (@(posedge clk) disable iff (!rst_n)
    link_valid[1] |-> (link_word[1].best_dist <= ncc_pkg::MAX_DIST))
    else $error("First cell did not replace the starting distance.");
`endif

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the nearest color centroid labeler with a label scoreboard.
module tb_top;

  localparam int HALF_PERIOD = 6;
  localparam int SETTLE      = 2 * ncc_pkg::MAX_CENTROIDS + 4;
  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 103;
  localparam int FILL_WORDS  = 60;
  localparam logic [ncc_pkg::CFG_IDX_W-1:0] REG_UNUSED =
    ncc_pkg::CFG_IDX_W'(ncc_pkg::MAX_CENTROIDS + 1);

  typedef logic [ncc_pkg::CENTROID_W-1:0] centroid_t;

  class label_scoreboard;
    logic [ncc_pkg::NUM_W-1:0] count_reg;
    centroid_t                 centroids[ncc_pkg::MAX_CENTROIDS];
    ncc_pkg::result_t          expected_labels[$];
    int                        errors;

    function new();
      count_reg = ncc_pkg::NUM_W'(ncc_pkg::MAX_CENTROIDS);
      foreach (centroids[k]) centroids[k] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [ncc_pkg::CFG_IDX_W-1:0] idx,
                            logic [ncc_pkg::CFG_DATA_W-1:0] data);
      if (idx == ncc_pkg::REG_NUM_CENTROIDS) begin
        count_reg = data[ncc_pkg::NUM_W-1:0];
      end else if (idx <= ncc_pkg::MAX_CENTROIDS) begin
        centroids[idx - ncc_pkg::REG_CENTROID_BASE] = data[ncc_pkg::CENTROID_W-1:0];
      end
    endfunction

    function int unsigned chan_gap_sq(logic [ncc_pkg::CHAN_W-1:0] a,
                                      logic [ncc_pkg::CHAN_W-1:0] b);
      int diff;
      diff = int'(a) - int'(b);
      return diff * diff;
    endfunction

    function ncc_pkg::result_t nearest_label(ncc_pkg::pixel_t p);
      int unsigned      active;
      int unsigned      cand_dist;
      int unsigned      best_dist;
      int unsigned      best_k;
      ncc_pkg::result_t r;
      if (count_reg == 0) begin
        active = 1;
      end else if (count_reg > ncc_pkg::MAX_CENTROIDS) begin
        active = ncc_pkg::MAX_CENTROIDS;
      end else begin
        active = count_reg;
      end
      best_k    = 0;
      best_dist = 0;
      for (int unsigned k = 0; k < active; k++) begin
        cand_dist = chan_gap_sq(p.pixel_ch0, centroids[k][ncc_pkg::CHAN_W-1:0])
                  + chan_gap_sq(p.pixel_ch1,
                                centroids[k][2*ncc_pkg::CHAN_W-1:ncc_pkg::CHAN_W])
                  + chan_gap_sq(p.pixel_ch2,
                                centroids[k][3*ncc_pkg::CHAN_W-1:2*ncc_pkg::CHAN_W]);
        if (k == 0 || cand_dist < best_dist) begin
          best_dist = cand_dist;
          best_k    = k;
        end
      end
      r.cluster_index    = ncc_pkg::IDX_W'(best_k);
      r.squared_distance = ncc_pkg::DIST_W'(best_dist);
      return r;
    endfunction

    function void note_pixel(ncc_pkg::pixel_t p);
      expected_labels = {expected_labels, nearest_label(p)};
    endfunction

    function void check_label(ncc_pkg::result_t got);
      ncc_pkg::result_t want;
      if (expected_labels.size() == 0) begin
        $error("result word with no pixel pending: cluster_index %0d squared_distance %0d",
               got.cluster_index, got.squared_distance);
        errors++;
        return;
      end
      want = expected_labels.pop_front();
      if (got.cluster_index !== want.cluster_index) begin
        $error("cluster_index: expected %0d, actual %0d", want.cluster_index,
               got.cluster_index);
        errors++;
      end
      if (got.squared_distance !== want.squared_distance) begin
        $error("squared_distance: expected %0d, actual %0d", want.squared_distance,
               got.squared_distance);
        errors++;
      end
    endfunction

    function int pending();
      return expected_labels.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  ncc_pkg::pixel_t                in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  ncc_pkg::result_t               out_data;
  logic                           cfg_we    = 1'b0;
  logic [ncc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ncc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bit                        steady   = 1'b0;
  bit                        no_gaps  = 1'b0;
  bit                        hold_req = 1'b0;
  int                        idle_cycles = 0;
  centroid_t                 plan[ncc_pkg::MAX_CENTROIDS];
  logic [ncc_pkg::NUM_W-1:0] plan_count;
  label_scoreboard           labels = new();

  always #HALF_PERIOD clk = ~clk;

  nearest_color_centroid_label u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ncc_pkg::CHAN_W-1:0] nudge(logic [ncc_pkg::CHAN_W-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ncc_pkg::CHAN_W'(v);
  endfunction

  function automatic ncc_pkg::pixel_t random_pixel();
    ncc_pkg::pixel_t p;
    centroid_t       c;
    int              roll;
    roll = $urandom_range(0, 9);
    c    = plan[$urandom_range(0, ncc_pkg::MAX_CENTROIDS - 1)];
    p    = ncc_pkg::pixel_t'($urandom());
    if (roll < 3) begin
      p.pixel_ch0 = nudge(c[ncc_pkg::CHAN_W-1:0]);
      p.pixel_ch1 = nudge(c[2*ncc_pkg::CHAN_W-1:ncc_pkg::CHAN_W]);
      p.pixel_ch2 = nudge(c[3*ncc_pkg::CHAN_W-1:2*ncc_pkg::CHAN_W]);
    end else if (roll == 3) begin
      p.pixel_ch0 = c[ncc_pkg::CHAN_W-1:0];
      p.pixel_ch1 = c[2*ncc_pkg::CHAN_W-1:ncc_pkg::CHAN_W];
      p.pixel_ch2 = c[3*ncc_pkg::CHAN_W-1:2*ncc_pkg::CHAN_W];
    end else if (roll == 4) begin
      p.pixel_ch0 = {ncc_pkg::CHAN_W{1'($urandom_range(0, 1))}};
      p.pixel_ch1 = {ncc_pkg::CHAN_W{1'($urandom_range(0, 1))}};
      p.pixel_ch2 = {ncc_pkg::CHAN_W{1'($urandom_range(0, 1))}};
    end
    return p;
  endfunction

  task automatic send_pixel(input ncc_pkg::pixel_t p);
    int gap;
    gap = (steady || no_gaps) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    labels.note_pixel(p);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (labels.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ncc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ncc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    labels.write_reg(idx, data);
  endtask

  task automatic apply_plan(input bit poke_unused);
    logic [ncc_pkg::CFG_DATA_W-1:0] count_word;
    pause_until_drained();
    if (poke_unused) write_reg(REG_UNUSED, ncc_pkg::CFG_DATA_W'($urandom()));
    count_word = ncc_pkg::CFG_DATA_W'($urandom());
    count_word[ncc_pkg::NUM_W-1:0] = plan_count;
    write_reg(ncc_pkg::REG_NUM_CENTROIDS, count_word);
    for (int k = 0; k < ncc_pkg::MAX_CENTROIDS; k++) begin
      write_reg(ncc_pkg::REG_CENTROID_BASE + ncc_pkg::CFG_IDX_W'(k), plan[k]);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) labels.check_label(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("nearest_color_centroid_label: mismatch");
        $finish;
      end
    end
  end

  initial begin : result_side
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = pick_gap();
          run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(0, 6);
        end
      end
    end
  end

  initial begin : pixel_side
    int roll;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: six centroids, all at black.
    send_pixel(ncc_pkg::pixel_t'{8'h00, 8'h00, 8'h00});
    send_pixel(ncc_pkg::pixel_t'{8'hff, 8'hff, 8'hff});
    send_pixel(ncc_pkg::pixel_t'{8'h80, 8'h7f, 8'h01});

    plan_count = ncc_pkg::NUM_W'(ncc_pkg::MAX_CENTROIDS);
    plan = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00, 24'h000002, 24'hffffff};
    apply_plan(1'b1);
    send_pixel(ncc_pkg::pixel_t'{8'h01, 8'h00, 8'h00});
    send_pixel(ncc_pkg::pixel_t'{8'hff, 8'hff, 8'hff});
    send_pixel(ncc_pkg::pixel_t'{8'hff, 8'h00, 8'h00});
    send_pixel(ncc_pkg::pixel_t'{8'h00, 8'hff, 8'h00});
    send_pixel(ncc_pkg::pixel_t'{8'h02, 8'h00, 8'h00});
    send_pixel(ncc_pkg::pixel_t'{8'h00, 8'h00, 8'hff});
    send_pixel(ncc_pkg::pixel_t'{8'h80, 8'h80, 8'h80});

    // A count of zero must behave as one.
    plan_count = '0;
    plan = '{24'hffffff, 24'h102030, 24'h102030, 24'h102030, 24'h102030, 24'h102030};
    apply_plan(1'b0);
    send_pixel(ncc_pkg::pixel_t'{8'h30, 8'h20, 8'h10});
    send_pixel(ncc_pkg::pixel_t'{8'h00, 8'h00, 8'h00});

    // A count above the maximum saturates, so the last centroid still takes part.
    plan_count = '1;
    plan = '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'h102030};
    apply_plan(1'b1);
    send_pixel(ncc_pkg::pixel_t'{8'h30, 8'h20, 8'h10});
    send_pixel(ncc_pkg::pixel_t'{8'h00, 8'h00, 8'h00});

    plan_count = ncc_pkg::NUM_W'(1);
    plan = '{24'h808080, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
    apply_plan(1'b0);
    send_pixel(ncc_pkg::pixel_t'{8'h00, 8'h00, 8'h00});
    send_pixel(ncc_pkg::pixel_t'{8'hff, 8'hff, 8'hff});

    plan_count = ncc_pkg::NUM_W'(2);
    plan = '{24'h123456, 24'h123456, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
    apply_plan(1'b0);
    send_pixel(ncc_pkg::pixel_t'{8'h56, 8'h34, 8'h12});
    send_pixel(ncc_pkg::pixel_t'{8'h9c, 8'he1, 8'h07});

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       plan_count = ncc_pkg::NUM_W'(1);
        1:       plan_count = ncc_pkg::NUM_W'(ncc_pkg::MAX_CENTROIDS);
        2:       plan_count = '0;
        3:       plan_count = '1;
        default: plan_count = ($urandom_range(0, 3) == 0)
                              ? ncc_pkg::NUM_W'(ncc_pkg::MAX_CENTROIDS)
                              : ncc_pkg::NUM_W'($urandom_range(0, 7));
      endcase
      for (int k = 0; k < ncc_pkg::MAX_CENTROIDS; k++) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          plan[k] = '0;
        end else if (roll == 1) begin
          plan[k] = '1;
        end else if (roll == 2 && k > 0) begin
          plan[k] = plan[k-1];
        end else begin
          plan[k] = centroid_t'($urandom());
        end
      end
      apply_plan(1'($urandom_range(0, 1)));
      steady = (phase == 4);
      if (phase == 5) begin
        hold_req = 1'b1;
        no_gaps  = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == FILL_WORDS) no_gaps = 1'b0;
        send_pixel(random_pixel());
      end
      no_gaps = 1'b0;
      steady  = 1'b0;
    end

    pause_until_drained();
    if (labels.errors == 0) begin
      $display("nearest_color_centroid_label: match");
    end else begin
      $display("nearest_color_centroid_label: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
sv/ncc_pkg.sv
sv/ncc_cell.sv
sv/nearest_color_centroid_label.sv
sim/tb_top.sv
